[design/cde_pkg.sv]
package cde_pkg;

  // field widths
  localparam int unsigned ModeW     = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned PosW      = 6;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

  // default number of store entries
  localparam int unsigned DefDepth = 16;

  // request modes
  localparam logic [ModeW-1:0] ModePushFront = 3'd0;
  localparam logic [ModeW-1:0] ModePushBack  = 3'd1;
  localparam logic [ModeW-1:0] ModePopFront  = 3'd2;
  localparam logic [ModeW-1:0] ModePopBack   = 3'd3;
  localparam logic [ModeW-1:0] ModeSearch    = 3'd4;
  localparam logic [ModeW-1:0] ModeView      = 3'd5;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty    = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd3;

endpackage

[design/cde_ram.sv]
module cde_ram #(
  parameter int unsigned WIDTH = cde_pkg::DataW,
  parameter int unsigned DEPTH = cde_pkg::DefDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/circular_deque_engine.sv]
// push, pop and empty/full responses: a response or pop state, then the result register
// search: walks the items from the front until a match or the last item
// view: one result per cycle from the store read port while the output is not stalled
// one request at a time; a new request is taken while the last result waits
// reset clears front index, item count and the output valid flag; store is not cleared
module circular_deque_engine #(
  parameter int unsigned DEPTH = cde_pkg::DefDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] mode, [34:3] value_in, [39:35] zero
  input  logic [cde_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] status, [33:2] value_out, [39:34] position
  output logic [cde_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StResp = 3'd1;
  localparam logic [2:0] StPop  = 3'd2;
  localparam logic [2:0] StSrch = 3'd3;
  localparam logic [2:0] StView = 3'd4;

  // circular index step, no divider
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [IdxW:0] sum;
    sum = (IdxW + 1)'(base) + (IdxW + 1)'(off);
    if (sum >= (IdxW + 1)'(DEPTH)) begin
      sum = sum - (IdxW + 1)'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  logic [2:0]                     state_q, state_d;
  logic [IdxW-1:0]                front_q, front_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic [IdxW-1:0]                ptr_q, ptr_d;
  logic signed [cde_pkg::DataW-1:0] key_q, key_d;
  logic [cde_pkg::StatusW-1:0]    res_status_q, res_status_d;

  logic [cde_pkg::ModeW-1:0]      in_mode;
  logic signed [cde_pkg::DataW-1:0] in_value;
  logic                           s_acc;
  logic                           out_free;
  logic                           idx_last;
  logic [IdxW-1:0]                front_dec;

  logic                           mem_we, mem_re;
  logic [IdxW-1:0]                mem_waddr, mem_raddr;
  logic [cde_pkg::DataW-1:0]      mem_rdata;

  logic                           emit;
  logic [cde_pkg::StatusW-1:0]    emit_status;
  logic [cde_pkg::DataW-1:0]      emit_value;
  logic [cde_pkg::PosW-1:0]       emit_pos;
  logic                           emit_last;

  logic                           out_valid_q;
  logic [cde_pkg::OutTdataW-1:0]  out_data_q;
  logic                           out_last_q;

  // request unpacking and handshake
  assign in_mode       = s_axis_tdata[cde_pkg::ModeW-1:0];
  assign in_value      = s_axis_tdata[cde_pkg::ModeW +: cde_pkg::DataW];
  assign s_axis_tready = (state_q == StIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign idx_last      = ((IdxW + 1)'(idx_q) + 1'b1) == (IdxW + 1)'(count_q);
  assign front_dec     = (front_q == '0) ? LastIdx : front_q - 1'b1;

  // item store
  cde_ram #(
    .WIDTH(cde_pkg::DataW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_value),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    ptr_d        = ptr_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = front_q;
    mem_re       = 1'b0;
    mem_raddr    = front_q;
    emit         = 1'b0;
    emit_status  = cde_pkg::StatusOk;
    emit_value   = '0;
    emit_pos     = '0;
    emit_last    = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          key_d = in_value;
          unique case (in_mode) inside
            cde_pkg::ModePushFront, cde_pkg::ModePushBack: begin
              state_d = StResp;
              if (count_q == FullCnt) begin
                res_status_d = cde_pkg::StatusFull;
              end else begin
                res_status_d = cde_pkg::StatusOk;
                mem_we       = 1'b1;
                count_d      = count_q + 1'b1;
                if (in_mode == cde_pkg::ModePushFront) begin
                  mem_waddr = front_dec;
                  front_d   = front_dec;
                end else begin
                  mem_waddr = slot_of(front_q, count_q);
                end
              end
            end
            cde_pkg::ModePopFront, cde_pkg::ModePopBack: begin
              if (count_q == '0) begin
                res_status_d = cde_pkg::StatusEmpty;
                state_d      = StResp;
              end else begin
                mem_re  = 1'b1;
                count_d = count_q - 1'b1;
                state_d = StPop;
                if (in_mode == cde_pkg::ModePopFront) begin
                  mem_raddr = front_q;
                  front_d   = idx_inc(front_q);
                end else begin
                  mem_raddr = slot_of(front_q, count_q - 1'b1);
                end
              end
            end
            cde_pkg::ModeSearch, cde_pkg::ModeView: begin
              if (count_q == '0) begin
                res_status_d = (in_mode == cde_pkg::ModeSearch) ?
                               cde_pkg::StatusNotFound : cde_pkg::StatusEmpty;
                state_d      = StResp;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q;
                ptr_d     = front_q;
                idx_d     = '0;
                state_d   = (in_mode == cde_pkg::ModeSearch) ? StSrch : StView;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StResp: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = res_status_q;
          state_d     = StIdle;
        end
      end
      StPop: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_value = mem_rdata;
          state_d    = StIdle;
        end
      end
      StSrch: begin
        // read data belongs to idx_q; the next read goes out while comparing
        if ((mem_rdata == key_q) || idx_last) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = StIdle;
            if (mem_rdata == key_q) begin
              emit_value = key_q;
              emit_pos   = cde_pkg::PosW'(idx_q);
            end else begin
              emit_status = cde_pkg::StatusNotFound;
            end
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc(ptr_q);
          ptr_d     = idx_inc(ptr_q);
          idx_d     = idx_q + 1'b1;
        end
      end
      StView: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_value = mem_rdata;
          emit_pos   = cde_pkg::PosW'(idx_q);
          emit_last  = idx_last;
          if (idx_last) begin
            state_d = StIdle;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_inc(ptr_q);
            ptr_d     = idx_inc(ptr_q);
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // walk and request holding registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    ptr_q        <= ptr_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {emit_pos, emit_value, emit_status};
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("item count beyond store depth");

  a_idle_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !emit)
    else $error("result produced with no request in progress");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (in_mode == cde_pkg::ModePushBack) && (count_q != FullCnt))
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted push did not grow the count");

  a_notlast_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !emit_last) |-> (state_q == StView))
    else $error("non-final result outside a view walk");

endmodule
